[design/sitda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int DIGIT_WIDTH = $clog2(NUM_DIGITS + 1);

   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } state_type;

endpackage

[design/sitda_dabble_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dabble_step
// One shift-and-add-3 step: adjust every BCD digit of 5 or more by 3, then
// shift the whole register left by one, taking in the next binary bit.
// ----------------------------------------------------------------------------
module sitda_dabble_step (
   input  logic [sitda_pkg::BCD_WIDTH-1:0] bcd_cur,
   input  logic                            bit_in,
   output logic [sitda_pkg::BCD_WIDTH-1:0] bcd_next
);
   import sitda_pkg::*;

   logic [BCD_WIDTH-1:0] adjusted;

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_cur[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = bcd_cur[4*d +: 4] + 4'd3;
         end else begin
            adjusted[4*d +: 4] = bcd_cur[4*d +: 4];
         end
      end
   end

   assign bcd_next = {adjusted[BCD_WIDTH-2:0], bit_in};

endmodule

[design/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer carries req_value, a two's complement integer.
//   rsp channel: one transfer per character, most significant first; a '-'
//   leads negative values, leading zeros are dropped, zero gives '0'.
//   rsp_last marks the final character of the run.
// Timing:
//   After a req transfer the magnitude runs through a shared shift-and-add-3
//   unit, one bit per cycle. Leading zero digits are then dropped one per
//   cycle until the first digit kept is found. Characters load into the output
//   register one per cycle while it is free of an untaken character, 1 to 11
//   of them. req_ready is high only between items.
// Reset:
//   reset returns the sequencer to idle and clears rsp_valid.
// Stall:
//   While rsp_valid is high and rsp_ready is low, the output register holds
//   its character and the sequencer waits in emit; the next item is taken once
//   the last character is loaded, even if it has not yet been transferred.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [7:0]                              rsp_character,
   output logic                                    rsp_last
);
   import sitda_pkg::*;

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [DIGIT_WIDTH-1:0]  digits_ff, digits_in;
   logic                    sign_ff, sign_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_character_ff, rsp_character_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [BCD_WIDTH-1:0]    bcd_step;
   logic [VALUE_WIDTH-1:0]  raw;
   logic                    out_free;
   logic                    top_zero;
   logic                    last_digit;

   sitda_dabble_step u_step (
      .bcd_cur  (bcd_ff),
      .bit_in   (mag_ff[VALUE_WIDTH-1]),
      .bcd_next (bcd_step)
   );

   assign raw        = req_value;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign top_zero   = (bcd_ff[BCD_WIDTH-1 -: 4] == 4'd0);
   assign last_digit = (digits_ff == DIGIT_WIDTH'(1));

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (count_ff == COUNT_WIDTH'(VALUE_WIDTH - 1)) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (!top_zero || last_digit) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && !sign_ff && last_digit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      count_in         = count_ff;
      digits_in        = digits_ff;
      sign_in          = sign_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sign_in   = raw[VALUE_WIDTH-1];
               mag_in    = raw[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - raw) : raw;
               bcd_in    = '0;
               count_in  = '0;
               digits_in = DIGIT_WIDTH'(NUM_DIGITS);
            end
         end
         ST_CONVERT: begin
            bcd_in   = bcd_step;
            mag_in   = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            count_in = count_ff + COUNT_WIDTH'(1);
         end
         ST_TRIM: begin
            if (top_zero && !last_digit) begin
               bcd_in    = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               digits_in = digits_ff - DIGIT_WIDTH'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_character_in = CHAR_MINUS;
                  rsp_last_in      = 1'b0;
                  sign_in          = 1'b0;
               end else begin
                  rsp_character_in = CHAR_ZERO + {4'd0, bcd_ff[BCD_WIDTH-1 -: 4]};
                  rsp_last_in      = last_digit;
                  bcd_in           = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
                  digits_in        = digits_ff - DIGIT_WIDTH'(1);
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         digits_ff    <= '0;
         sign_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         digits_ff    <= digits_in;
         sign_ff      <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last character");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character != CHAR_MINUS |->
         rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE)
      else $error("character is neither minus nor digit");

   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TRIM || state_ff == ST_EMIT |-> digits_ff != '0)
      else $error("no digits left while trimming or emitting");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && !sign_ff && last_digit |=>
         state_ff == ST_IDLE && rsp_valid && rsp_last)
      else $error("final digit did not end the run");

endmodule
